// File: sv/button_event_qualifier_macros.svh
// Assertion macros used by the checker file of the button event qualifier.
// Each macro expects a signal named clock, and all but the last one named reset, in the scope where it is used.
`ifndef BUTTON_EVENT_QUALIFIER_MACROS_SVH
`define BUTTON_EVENT_QUALIFIER_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define BEQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, ignored while reset is high.
`define BEQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define BEQ_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: sv/beq_pkg.sv
`default_nettype none
package beq_pkg;

   localparam int TIME_W     = 32;
   localparam int HOLD_W     = 16;
   localparam int DEBOUNCE_W = 8;
   localparam int EVENT_W    = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int REG_IDX_W  = 2;

   // Event codes.
   localparam logic [EVENT_W-1:0] EV_NONE         = 3'd0;
   localparam logic [EVENT_W-1:0] EV_DELETE_LONG  = 3'd1;
   localparam logic [EVENT_W-1:0] EV_PLAY_LONG    = 3'd2;
   localparam logic [EVENT_W-1:0] EV_RECORD_SHORT = 3'd3;
   localparam logic [EVENT_W-1:0] EV_PLAY_SHORT   = 3'd4;

   // Register indexes, taken from paddr[3:2].
   localparam logic [REG_IDX_W-1:0] REG_DELETE_HOLD = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_PLAY_HOLD   = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE    = 2'd2;

   // Reset values of the registers.
   localparam logic [HOLD_W-1:0]     DELETE_HOLD_RESET = 16'd2000;
   localparam logic [HOLD_W-1:0]     PLAY_HOLD_RESET   = 16'd1000;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET    = 8'd30;

   typedef struct packed {
      logic [HOLD_W-1:0]     delete_hold_ms;
      logic [HOLD_W-1:0]     play_hold_ms;
      logic [DEBOUNCE_W-1:0] debounce_ms;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0] press_start;
      logic              armed;
      logic              fired;
   } hold_state_type;

   typedef struct packed {
      logic [TIME_W-1:0] change_time;
      logic              stable_level;
   } edge_state_type;

   typedef struct packed {
      hold_state_type delete_trk;
      hold_state_type play_trk;
      edge_state_type record_edge;
      edge_state_type play_edge;
   } state_type;

   typedef struct packed {
      hold_state_type st;
      logic           fire;
   } hold_result_type;

   typedef struct packed {
      edge_state_type st;
      logic           fire;
   } edge_result_type;

endpackage
`default_nettype wire

// File: sv/beq_if.sv
`default_nettype none
interface beq_req_if;
   import beq_pkg::*;

   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] now_ms;
   logic              record_level;
   logic              play_level;
   logic              delete_level;

   modport source(output valid, now_ms, record_level, play_level, delete_level,
                  input ready);
   modport sink(input valid, now_ms, record_level, play_level, delete_level,
                output ready);
endinterface

interface beq_rsp_if;
   import beq_pkg::*;

   logic               valid;
   logic               ready;
   logic [EVENT_W-1:0] event_code;

   modport source(output valid, event_code, input ready);
   modport sink(input valid, event_code, output ready);
endinterface
`default_nettype wire

// File: sv/beq_csr.sv
`default_nettype none
module beq_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [beq_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [beq_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [beq_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready,
   output beq_pkg::cfg_type                    cfg
);
   import beq_pkg::*;

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic                 wr_en;
   logic [REG_IDX_W-1:0] idx;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-REG_IDX_W];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_DELETE_HOLD: cfg_in.delete_hold_ms = csr_pwdata[HOLD_W-1:0];
            REG_PLAY_HOLD:   cfg_in.play_hold_ms   = csr_pwdata[HOLD_W-1:0];
            REG_DEBOUNCE:    cfg_in.debounce_ms    = csr_pwdata[DEBOUNCE_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_DELETE_HOLD: csr_prdata = {{(CSR_DATA_W-HOLD_W){1'b0}}, cfg_ff.delete_hold_ms};
         REG_PLAY_HOLD:   csr_prdata = {{(CSR_DATA_W-HOLD_W){1'b0}}, cfg_ff.play_hold_ms};
         REG_DEBOUNCE:    csr_prdata = {{(CSR_DATA_W-DEBOUNCE_W){1'b0}}, cfg_ff.debounce_ms};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delete_hold_ms <= DELETE_HOLD_RESET;
         cfg_ff.play_hold_ms   <= PLAY_HOLD_RESET;
         cfg_ff.debounce_ms    <= DEBOUNCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// File: sv/beq_eval.sv
`default_nettype none
module beq_eval (
   input  wire beq_pkg::cfg_type           cfg,
   input  wire beq_pkg::state_type         st,
   input  wire logic [beq_pkg::TIME_W-1:0] now_ms,
   input  wire logic                       record_level,
   input  wire logic                       play_level,
   input  wire logic                       delete_level,
   output beq_pkg::state_type              st_next,
   output logic      [beq_pkg::EVENT_W-1:0] event_code
);
   import beq_pkg::*;

   // One long-press tracker step; the level is active low.
   function automatic hold_result_type hold_step(hold_state_type t, logic level,
                                                 logic [TIME_W-1:0] now,
                                                 logic [HOLD_W-1:0] hold);
      hold_result_type   r;
      logic [TIME_W-1:0] start;
      logic              fired0;
      logic [TIME_W-1:0] diff;
      r      = '{st: t, fire: 1'b0};
      start  = t.armed ? t.press_start : now;
      fired0 = t.armed & t.fired;
      diff   = now - start;
      if (!level) begin
         r.fire           = !fired0 && (diff >= {{(TIME_W-HOLD_W){1'b0}}, hold});
         r.st.armed       = 1'b1;
         r.st.press_start = start;
         r.st.fired       = fired0 | r.fire;
      end else begin
         r.st.armed = 1'b0;
         r.st.fired = 1'b0;
      end
      return r;
   endfunction

   // One debounced edge step; only a change to low reports an edge.
   function automatic edge_result_type edge_step(edge_state_type e, logic level,
                                                 logic [TIME_W-1:0] now,
                                                 logic [DEBOUNCE_W-1:0] deb);
      edge_result_type   r;
      logic [TIME_W-1:0] diff;
      r    = '{st: e, fire: 1'b0};
      diff = now - e.change_time;
      if ((level != e.stable_level) && (diff > {{(TIME_W-DEBOUNCE_W){1'b0}}, deb})) begin
         r.st.change_time  = now;
         r.st.stable_level = level;
         r.fire            = !level;
      end
      return r;
   endfunction

   hold_result_type del_r;
   hold_result_type ply_r;
   edge_result_type rec_e;
   edge_result_type ply_e;

   always_comb begin
      del_r = hold_step(st.delete_trk, delete_level, now_ms, cfg.delete_hold_ms);
      ply_r = hold_step(st.play_trk, play_level, now_ms, cfg.play_hold_ms);
      rec_e = edge_step(st.record_edge, record_level, now_ms, cfg.debounce_ms);
      ply_e = edge_step(st.play_edge, play_level, now_ms, cfg.debounce_ms);

      // Later checks only commit their state when no earlier check fired.
      st_next            = st;
      st_next.delete_trk = del_r.st;
      event_code         = EV_NONE;
      if (del_r.fire) begin
         event_code = EV_DELETE_LONG;
      end else begin
         st_next.play_trk = ply_r.st;
         if (ply_r.fire) begin
            event_code = EV_PLAY_LONG;
         end else begin
            st_next.record_edge = rec_e.st;
            if (rec_e.fire) begin
               event_code = EV_RECORD_SHORT;
            end else begin
               st_next.play_edge = ply_e.st;
               if (ply_e.fire) begin
                  event_code = EV_PLAY_SHORT;
               end
            end
         end
      end
   end

endmodule
`default_nettype wire

// File: sv/button_event_qualifier.sv
// Each accepted item passes the input register and then the result register before it is taken.
// Throughput: one item per cycle while the receiver takes results; the tracker state is
// updated by the evaluation logic between the input register and the result register.
// A stalled result holds while one more item waits in the input register.
// Synchronous reset empties both registers, restores the trackers to released
// and unarmed, and loads the hold and debounce registers with 2000, 1000 and 30.
`default_nettype none
module button_event_qualifier (
   input  wire logic                           clock,
   input  wire logic                           reset,
   beq_req_if.sink                             req,
   beq_rsp_if.source                           rsp,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [beq_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [beq_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [beq_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);
   import beq_pkg::*;

   cfg_type cfg;

   // Input register: holds one accepted poll item until it can be evaluated.
   logic              in_valid_ff;
   logic              in_valid_in;
   logic [TIME_W-1:0] in_now_ff;
   logic              in_record_ff;
   logic              in_play_ff;
   logic              in_delete_ff;

   // Result register.
   logic               out_valid_ff;
   logic               out_valid_in;
   logic [EVENT_W-1:0] out_event_ff;

   // Tracker and detector state.
   state_type          st_ff;
   state_type          st_in;
   state_type          st_eval;
   logic [EVENT_W-1:0] event_eval;

   logic advance;
   logic accept;

   beq_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .cfg        (cfg)
   );

   beq_eval u_eval (
      .cfg         (cfg),
      .st          (st_ff),
      .now_ms      (in_now_ff),
      .record_level(in_record_ff),
      .play_level  (in_play_ff),
      .delete_level(in_delete_ff),
      .st_next     (st_eval),
      .event_code  (event_eval)
   );

   // The held item moves into the result register whenever that register
   // is empty or its item is being taken this cycle. The state is committed
   // at the same edge, so the next item is evaluated against it.
   assign advance   = in_valid_ff & (~out_valid_ff | rsp.ready);
   assign req.ready = ~in_valid_ff | advance;
   assign accept    = req.valid & req.ready;

   assign in_valid_in  = accept | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp.ready);
   assign st_in        = advance ? st_eval : st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_now_ff    <= req.now_ms;
         in_record_ff <= req.record_level;
         in_play_ff   <= req.play_level;
         in_delete_ff <= req.delete_level;
      end
      if (advance) begin
         out_event_ff <= event_eval;
      end
   end

   // The trackers start released and unarmed, with zero time stamps.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.delete_trk  <= '{press_start: '0, armed: 1'b0, fired: 1'b0};
         st_ff.play_trk    <= '{press_start: '0, armed: 1'b0, fired: 1'b0};
         st_ff.record_edge <= '{change_time: '0, stable_level: 1'b1};
         st_ff.play_edge   <= '{change_time: '0, stable_level: 1'b1};
      end else begin
         st_ff <= st_in;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.event_code = out_event_ff;

endmodule
`default_nettype wire

// File: sv/beq_checker.sv
`default_nettype none
`include "button_event_qualifier_macros.svh"
module beq_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [beq_pkg::EVENT_W-1:0] rsp_event_code
);
   import beq_pkg::*;

   // Reset always leaves the result side empty.
   `BEQ_ASSERT_NEXT_ALWAYS(a_reset_empties, reset, !rsp_valid)
   // With no result waiting, the block must take a new item.
   `BEQ_ASSERT_NOW(a_ready_when_empty, !rsp_valid, req_ready)
   // A new result only appears once an item was taken and passed the input register.
   `BEQ_ASSERT_NOW(a_no_invented_result, $rose(rsp_valid), $past(req_valid && req_ready, 2))
   // A stalled result holds its code.
   `BEQ_ASSERT_NEXT(a_stall_holds, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_event_code))

endmodule

bind button_event_qualifier beq_checker u_beq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_event_code(rsp.event_code)
);
`default_nettype wire

// File: verif/beq_tb_pkg.sv
package beq_tb_pkg;
   import beq_pkg::*;

   // Bit-accurate copy of the button trackers. Every accepted poll leaves
   // one expected event code in a queue, and results are checked in order.
   class button_event_tracker;
      cfg_type            cfg;
      hold_state_type     delete_hold;
      hold_state_type     play_hold;
      edge_state_type     record_edge;
      edge_state_type     play_edge;
      logic [EVENT_W-1:0] expected_events[$];
      int unsigned        mismatches;

      function new();
         cfg.delete_hold_ms       = DELETE_HOLD_RESET;
         cfg.play_hold_ms         = PLAY_HOLD_RESET;
         cfg.debounce_ms          = DEBOUNCE_RESET;
         delete_hold              = '0;
         play_hold                = '0;
         record_edge.change_time  = '0;
         record_edge.stable_level = 1'b1;
         play_edge.change_time    = '0;
         play_edge.stable_level   = 1'b1;
         mismatches               = 0;
      endfunction

      function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_DELETE_HOLD: cfg.delete_hold_ms = data[HOLD_W-1:0];
            REG_PLAY_HOLD:   cfg.play_hold_ms   = data[HOLD_W-1:0];
            REG_DEBOUNCE:    cfg.debounce_ms    = data[DEBOUNCE_W-1:0];
            default: ;
         endcase
      endfunction

      // Returns 1 on the one poll at which a press has been held long enough.
      function bit hold_reached(inout hold_state_type trk, input logic level,
                                input logic [TIME_W-1:0] now,
                                input logic [HOLD_W-1:0] hold);
         logic [TIME_W-1:0] held;
         if (!level) begin
            if (!trk.armed) begin
               trk.armed       = 1'b1;
               trk.fired       = 1'b0;
               trk.press_start = now;
            end
            held = now - trk.press_start;
            if (!trk.fired && held >= hold) begin
               trk.fired = 1'b1;
               return 1'b1;
            end
         end else begin
            trk.armed = 1'b0;
            trk.fired = 1'b0;
         end
         return 1'b0;
      endfunction

      // Returns 1 when a debounced change to the pressed level is taken.
      function bit press_edge(inout edge_state_type edg, input logic level,
                              input logic [TIME_W-1:0] now);
         logic [TIME_W-1:0] since;
         since = now - edg.change_time;
         if (level != edg.stable_level && since > cfg.debounce_ms) begin
            edg.change_time  = now;
            edg.stable_level = level;
            return !level;
         end
         return 1'b0;
      endfunction

      function void note_poll(logic [TIME_W-1:0] now, logic rec, logic ply, logic del);
         logic [EVENT_W-1:0] ev;
         if (hold_reached(delete_hold, del, now, cfg.delete_hold_ms))
            ev = EV_DELETE_LONG;
         else if (hold_reached(play_hold, ply, now, cfg.play_hold_ms))
            ev = EV_PLAY_LONG;
         else if (press_edge(record_edge, rec, now))
            ev = EV_RECORD_SHORT;
         else if (press_edge(play_edge, ply, now))
            ev = EV_PLAY_SHORT;
         else
            ev = EV_NONE;
         expected_events.push_back(ev);
      endfunction

      function void check_event(logic [EVENT_W-1:0] got);
         logic [EVENT_W-1:0] want;
         if (expected_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("event code %0d arrived with no poll outstanding", got);
            return;
         end
         want = expected_events.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("event code mismatch: expected %0d, got %0d", want, got);
         end
      endfunction

      function int unsigned pending();
         return expected_events.size();
      endfunction
   endclass

endpackage

// File: verif/button_event_qualifier_tb.sv
module button_event_qualifier_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import beq_pkg::*;
   import beq_tb_pkg::*;

   // The run ends in failure if this many cycles pass without a single item
   // moving on either channel. The longest sender gap and receiver stall are
   // both far below this limit, so it is generous.
   localparam int unsigned QUIET_LIMIT     = 4000;
   localparam int unsigned PHASES          = 8;
   localparam int unsigned ITEMS_PER_PHASE = 200;
   // An index past the end of the register file; writes to it are ignored.
   localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   beq_req_if req();
   beq_rsp_if rsp();

   button_event_qualifier u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   button_event_tracker tracker = new();

   // Idling controls, switched per phase so that some stretches run flat out.
   bit                req_gaps_on;
   bit                rsp_stalls_on;
   int unsigned       rsp_stall_left;
   int unsigned       quiet_cycles;

   // State of the random button model: the millisecond clock, the level each
   // button is heading for, and how many polls of contact bounce remain.
   logic [TIME_W-1:0] cur_ms;
   logic [2:0]        target_level;
   int unsigned       bounce_left[3];
   int unsigned       toggle_pct;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int unsigned pick_gap(bit enabled);
      int unsigned r;
      if (!enabled)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // Offers one poll after an optional gap and waits until the block takes it.
   // The valid stays high afterwards; the next call either lowers it for a gap
   // or presents the next item at the following falling edge.
   task automatic send_poll(logic [TIME_W-1:0] now, logic rec, logic ply, logic del);
      int unsigned gap;
      gap = pick_gap(req_gaps_on);
      repeat (gap) begin
         @(negedge clock);
         req.valid = 1'b0;
      end
      @(negedge clock);
      req.valid        = 1'b1;
      req.now_ms       = now;
      req.record_level = rec;
      req.play_level   = ply;
      req.delete_level = del;
      do @(posedge clock); while (!req.ready);
      tracker.note_poll(req.now_ms, req.record_level, req.play_level, req.delete_level);
   endtask

   // Stops offering items and waits until every expected event has come out.
   // As each poll gives exactly one event, the block is idle afterwards.
   task automatic drain();
      @(negedge clock);
      req.valid = 1'b0;
      while (tracker.pending() != 0)
         @(posedge clock);
   endtask

   // Register write: a setup phase, then an access phase with penable high.
   task automatic csr_write(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.write_reg(idx, data);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // Writes all three registers. The bits above each field are filled with
   // rubbish so that the block is seen to ignore them.
   task automatic program_cfg(logic [HOLD_W-1:0] del_hold, logic [HOLD_W-1:0] ply_hold,
                              logic [DEBOUNCE_W-1:0] debounce);
      logic [CSR_DATA_W-1:0] data;
      data = $urandom();
      data[HOLD_W-1:0] = del_hold;
      csr_write(REG_DELETE_HOLD, data);
      data = $urandom();
      data[HOLD_W-1:0] = ply_hold;
      csr_write(REG_PLAY_HOLD, data);
      data = $urandom();
      data[DEBOUNCE_W-1:0] = debounce;
      csr_write(REG_DEBOUNCE, data);
   endtask

   // Random polls from a simple button model. Time mostly creeps forward in
   // small steps, with the odd long jump and the odd jump to anywhere at all,
   // which may go backwards or across the wrap. Buttons are pressed and
   // released now and then, each change followed by a few polls of bounce,
   // and a small share of polls carry random levels as noise. Halfway through
   // the sender holds off until the block has nothing left in flight.
   task automatic random_polls(int unsigned count);
      logic [2:0]  lvl;
      int unsigned r;
      for (int unsigned i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 55)
            cur_ms += $urandom_range(0, 15);
         else if (r < 85)
            cur_ms += $urandom_range(0, 80);
         else if (r < 97)
            cur_ms += $urandom_range(0, 3000);
         else if (r < 99)
            cur_ms += $urandom_range(0, 70000);
         else
            cur_ms = $urandom();
         for (int b = 0; b < 3; b++) begin
            if ($urandom_range(0, 99) < toggle_pct) begin
               target_level[b] = ~target_level[b];
               bounce_left[b]  = $urandom_range(0, 3);
            end
            if (bounce_left[b] != 0) begin
               lvl[b] = 1'($urandom_range(0, 1));
               bounce_left[b]--;
            end else begin
               lvl[b] = target_level[b];
            end
         end
         if ($urandom_range(0, 99) < 8)
            lvl = 3'($urandom_range(0, 7));
         if (i == count / 2)
            drain();
         send_poll(cur_ms, lvl[0], lvl[1], lvl[2]);
      end
   endtask

   // The receiver's ready: high by default, with random stalls when enabled.
   always @(negedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp.ready = 1'b0;
         rsp_stall_left--;
      end else begin
         rsp.ready = 1'b1;
         if (rsp_stalls_on && $urandom_range(0, 99) < 35)
            rsp_stall_left = pick_gap(1'b1);
      end
   end

   // Every event the block hands over is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         tracker.check_event(rsp.event_code);
   end

   // Watchdog on progress: any accepted item on either channel resets the count.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      req.valid        = 1'b0;
      req.now_ms       = '0;
      req.record_level = 1'b1;
      req.play_level   = 1'b1;
      req.delete_level = 1'b1;
      rsp.ready        = 1'b1;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      req_gaps_on      = 1'b0;
      rsp_stalls_on    = 1'b0;
      rsp_stall_left   = 0;
      quiet_cycles     = 0;
      cur_ms           = '0;
      target_level     = 3'b111;
      toggle_pct       = 5;
      for (int b = 0; b < 3; b++)
         bounce_left[b] = 0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed polls with the reset settings. A record press exactly at the
      // debounce time is ignored and one a millisecond later is taken; play
      // gives a short event on its edge and a long one after its hold time;
      // delete fires once after two seconds. Then time jumps to the top of
      // the range and wraps round to a small value.
      send_poll(32'd0,    1'b1, 1'b1, 1'b1);
      send_poll(32'd30,   1'b0, 1'b1, 1'b1);
      send_poll(32'd31,   1'b0, 1'b1, 1'b1);
      send_poll(32'd40,   1'b0, 1'b0, 1'b1);
      send_poll(32'd1040, 1'b0, 1'b0, 1'b1);
      send_poll(32'd1041, 1'b0, 1'b0, 1'b1);
      send_poll(32'd1100, 1'b0, 1'b0, 1'b0);
      send_poll(32'd3100, 1'b0, 1'b0, 1'b0);
      send_poll(32'd3101, 1'b1, 1'b1, 1'b1);
      send_poll(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
      send_poll(32'h0000_0010, 1'b0, 1'b0, 1'b0);
      drain();

      // Zero hold and zero debounce: a long press fires on the very poll
      // that arms it, and two polls with the same time never count as a
      // change however the levels move.
      program_cfg('0, '0, '0);
      send_poll(32'd100, 1'b1, 1'b1, 1'b1);
      send_poll(32'd101, 1'b1, 1'b1, 1'b0);
      send_poll(32'd102, 1'b1, 1'b0, 1'b1);
      send_poll(32'd102, 1'b0, 1'b0, 1'b1);
      send_poll(32'd102, 1'b1, 1'b0, 1'b1);
      send_poll(32'd103, 1'b1, 1'b0, 1'b1);
      drain();

      // Largest hold and debounce: delete fires at exactly 65535 ms held,
      // and a change after exactly 255 ms is still too early.
      program_cfg('1, '1, '1);
      send_poll(32'd200000, 1'b1, 1'b1, 1'b1);
      send_poll(32'd200001, 1'b1, 1'b1, 1'b0);
      send_poll(32'd265535, 1'b1, 1'b1, 1'b0);
      send_poll(32'd265536, 1'b1, 1'b1, 1'b0);
      send_poll(32'd265537, 1'b1, 1'b1, 1'b1);
      send_poll(32'd266000, 1'b0, 1'b1, 1'b1);
      send_poll(32'd266255, 1'b1, 1'b1, 1'b1);
      send_poll(32'd266256, 1'b1, 1'b1, 1'b1);

      // Random phases, each with its own settings and idling. Phases 0 and 4
      // run with no idling on either side; 5 and 6 idle on one side only.
      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase)
            0: program_cfg(DELETE_HOLD_RESET, PLAY_HOLD_RESET, DEBOUNCE_RESET);
            1: program_cfg('0, '0, '0);
            2: program_cfg('1, '1, '1);
            3: begin
               program_cfg(HOLD_W'($urandom_range(0, 400)),
                           HOLD_W'($urandom_range(0, 300)),
                           DEBOUNCE_W'($urandom_range(0, 40)));
               csr_write(REG_UNUSED, $urandom());
            end
            default: program_cfg(HOLD_W'($urandom_range(0, 400)),
                                 HOLD_W'($urandom_range(0, 300)),
                                 DEBOUNCE_W'($urandom_range(0, 40)));
         endcase
         req_gaps_on   = (phase != 0 && phase != 4 && phase != 6);
         rsp_stalls_on = (phase != 0 && phase != 4 && phase != 5);
         toggle_pct    = $urandom_range(3, 15);
         random_polls(ITEMS_PER_PHASE);
      end

      drain();
      repeat (8) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: files.f
+incdir+sv
sv/beq_pkg.sv
sv/beq_if.sv
sv/beq_csr.sv
sv/beq_eval.sv
sv/button_event_qualifier.sv
sv/beq_checker.sv
verif/beq_tb_pkg.sv
verif/button_event_qualifier_tb.sv
